[sv/aes_pkg.sv]
`default_nettype none
package aes_pkg;

  localparam int NumRounds   = 14;
  localparam int MaxKeyWords = 60;
  localparam int AddrWidth   = 6;

  typedef logic [1:0] key_size_t;
  localparam key_size_t KeySize128 = 2'd0;
  localparam key_size_t KeySize192 = 2'd1;
  localparam key_size_t KeySize256 = 2'd2;

  localparam logic [AddrWidth-1:0] AddrKeySize = 6'h00;
  localparam logic [AddrWidth-1:0] AddrKeyWord0 = 6'h08;
  localparam logic [AddrWidth-1:0] AddrKeyWord1 = 6'h10;
  localparam logic [AddrWidth-1:0] AddrKeyWord2 = 6'h18;
  localparam logic [AddrWidth-1:0] AddrKeyWord3 = 6'h20;

  typedef logic [127:0] block_t;

  typedef struct packed {
    logic      last;
    logic      pass;
    key_size_t size;
  } round_ctl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

  localparam logic [7:0] RCON [11] = '{
    8'h8D,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1B,8'h36
  };

  // reserved size decodes as 128 bits
  function automatic logic [3:0] num_rounds(input key_size_t s);
    case (s)
      KeySize192: num_rounds = 4'd12;
      KeySize256: num_rounds = 4'd14;
      default:    num_rounds = 4'd10;
    endcase
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic logic [31:0] mix_column(input logic [31:0] w);
    logic [7:0] a0, a1, a2, a3;
    a0 = w[31:24]; a1 = w[23:16]; a2 = w[15:8]; a3 = w[7:0];
    mix_column = {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                  a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                  a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                  xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
  endfunction

  // SubBytes then ShiftRows; column c, row r from column c+r
  function automatic block_t sub_shift(input block_t s);
    block_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 32*c - 8*r -: 8] = SBOX[s[127 - 32*((c + r) % 4) - 8*r -: 8]];
      end
    end
    sub_shift = t;
  endfunction

  function automatic block_t mix_columns(input block_t s);
    block_t t;
    for (int c = 0; c < 4; c++) begin
      t[127 - 32*c -: 32] = mix_column(s[127 - 32*c -: 32]);
    end
    mix_columns = t;
  endfunction

endpackage
`default_nettype wire

[sv/aes_key_exp.sv]
`default_nettype none
// Key schedule, one word per cycle into a 60-word shift chain; runs after each key write.
// All 60 words are always produced; words past the key size's total are unused.
module aes_key_exp import aes_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         restart,
  input  wire logic [1:0]   key_size,
  input  wire logic [255:0] key,
  output logic [1919:0]     round_keys,
  output logic              done
);

  logic [31:0] chain [MaxKeyWords];
  logic [31:0] key_w [8];
  logic [5:0]  cnt;
  logic [3:0]  nk;
  logic [3:0]  grp_pos;
  logic [3:0]  rcon_idx;
  logic [31:0] t, back, nw;

  always_comb begin
    case (key_size)
      KeySize192: nk = 4'd6;
      KeySize256: nk = 4'd8;
      default:    nk = 4'd4;
    endcase
  end

  // chain[0] is the newest word, so w[i-nk] sits at chain[nk-1]
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      key_w[i] = key[255 - 32*i -: 32];
    end
    t = chain[0];
    case (key_size)
      KeySize192: back = chain[5];
      KeySize256: back = chain[7];
      default:    back = chain[3];
    endcase
    if (cnt < {2'b00, nk}) begin
      nw = key_w[cnt[2:0]];
    end else if (grp_pos == 4'd0) begin
      nw = sub_word({t[23:0], t[31:24]}) ^ {RCON[rcon_idx], 24'h0} ^ back;
    end else if (nk == 4'd8 && grp_pos == 4'd4) begin
      nw = sub_word(t) ^ back;
    end else begin
      nw = t ^ back;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      cnt      <= 6'd0;
      grp_pos  <= 4'd0;
      rcon_idx <= 4'd0;
      done     <= 1'b0;
    end else if (!done) begin
      cnt <= cnt + 6'd1;
      if (cnt == 6'(MaxKeyWords - 1)) begin
        done <= 1'b1;
      end
      if (grp_pos == nk - 4'd1) begin
        grp_pos  <= 4'd0;
        rcon_idx <= (rcon_idx == 4'd10) ? 4'd0 : rcon_idx + 4'd1;
      end else begin
        grp_pos <= grp_pos + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst && !restart && !done) begin
      chain[0] <= nw;
      for (int i = 1; i < MaxKeyWords; i++) begin
        chain[i] <= chain[i-1];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MaxKeyWords; i++) begin
      round_keys[1919 - 32*i -: 32] = chain[MaxKeyWords - 1 - i];
    end
  end

endmodule
`default_nettype wire

[sv/aes_round.sv]
`default_nettype none
module aes_round import aes_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire block_t     in_state,
  input  wire round_ctl_t in_ctl,
  input  wire block_t     round_key,
  output logic            out_valid,
  output block_t          out_state,
  output round_ctl_t      out_ctl
);

  block_t ss;

  always_comb begin
    ss = sub_shift(in_state);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_ctl <= in_ctl;
    if (in_ctl.pass) begin
      out_state <= in_state;
    end else if (in_ctl.last) begin
      out_state <= ss ^ round_key;
    end else begin
      out_state <= mix_columns(ss) ^ round_key;
    end
  end

endmodule
`default_nettype wire

[sv/aes_block_encrypt.sv]
`default_nettype none
// The key-add register and 14 round stages lie between the edge that accepts start and done.
// Throughput: one item per cycle while busy is low; shorter keys pass unchanged through the unused round stages.
// A key write restarts the schedule: busy is high in the write cycle and until all 60 words are produced.
// Reset clears the key registers and valid bits to 0 and expands the all-zero 128-bit key (busy meanwhile).
// The receiver cannot stall: done is a one-cycle strobe.
module aes_block_encrypt import aes_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [AddrWidth-1:0] paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [63:0] plain_high,
  input  wire logic [63:0] plain_low,
  output logic             done,
  output logic [63:0]      cipher_high,
  output logic [63:0]      cipher_low
);

  logic [1:0]  key_size;
  logic [63:0] key_word_0, key_word_1, key_word_2, key_word_3;
  logic        wr, ks_done;
  logic [1919:0] rk;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_size <= KeySize128;
      key_word_0 <= '0; key_word_1 <= '0; key_word_2 <= '0; key_word_3 <= '0;
    end else if (wr) begin
      case (paddr)
        AddrKeySize:  key_size <= pwdata[1:0];
        AddrKeyWord0: key_word_0 <= pwdata;
        AddrKeyWord1: key_word_1 <= pwdata;
        AddrKeyWord2: key_word_2 <= pwdata;
        AddrKeyWord3: key_word_3 <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      AddrKeySize:  prdata = {62'd0, key_size};
      AddrKeyWord0: prdata = key_word_0;
      AddrKeyWord1: prdata = key_word_1;
      AddrKeyWord2: prdata = key_word_2;
      AddrKeyWord3: prdata = key_word_3;
      default:      prdata = '0;
    endcase
  end

  aes_key_exp u_key (
    .clk, .rst, .restart(wr),
    .key_size, .key({key_word_0, key_word_1, key_word_2, key_word_3}),
    .round_keys(rk), .done(ks_done)
  );

  assign busy = !ks_done || wr;

  logic       in_v;
  block_t     in_st;
  key_size_t  in_sz;

  logic       v  [NumRounds+1];
  block_t     st [NumRounds+1];
  key_size_t  sz [NumRounds+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else begin
      in_v <= start && !busy;
    end
    in_st <= {plain_high, plain_low} ^ rk[1919 -: 128];
    in_sz <= key_size;
  end

  assign v[0]  = in_v;
  assign st[0] = in_st;
  assign sz[0] = in_sz;

  for (genvar r = 1; r <= NumRounds; r++) begin : g_round
    localparam logic [3:0] RoundIdx = 4'(r);
    logic [3:0] nr_in;
    round_ctl_t c_in;
    round_ctl_t c_out;
    assign nr_in = num_rounds(sz[r-1]);
    assign c_in  = '{last: (nr_in == RoundIdx), pass: (nr_in < RoundIdx), size: sz[r-1]};
    aes_round u_round (
      .clk, .rst,
      .in_valid(v[r-1]), .in_state(st[r-1]), .in_ctl(c_in),
      .round_key(rk[1919 - 128*r -: 128]),
      .out_valid(v[r]), .out_state(st[r]), .out_ctl(c_out)
    );
    assign sz[r] = c_out.size;
  end

  assign done = v[NumRounds];
  assign cipher_high = st[NumRounds][127:64];
  assign cipher_low  = st[NumRounds][63:0];

endmodule
`default_nettype wire

[test/tb_aes_block_encrypt.sv]
`default_nettype none
module tb_aes_block_encrypt;
  import aes_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic [63:0] plain_high = '0, plain_low = '0;
  logic done;
  logic [63:0] cipher_high, cipher_low;

  aes_block_encrypt u_dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy), .plain_high(plain_high), .plain_low(plain_low),
    .done(done), .cipher_high(cipher_high), .cipher_low(cipher_low)
  );

  always #5 clk = ~clk;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
  } blk_pair_t;

  key_size_t cfg_size;
  logic [63:0] cfg_key [4];

  blk_pair_t pending_blocks[$];
  blk_pair_t expected_cipher[$];
  int gap_left;
  bit no_gaps;
  bit failed;
  int quiet_cycles;

  function automatic blk_pair_t aes_encrypt(blk_pair_t p);
    logic [31:0] w [MaxKeyWords];
    logic [31:0] t;
    block_t s, rk;
    int nk, nr;
    blk_pair_t r;
    if (cfg_size == KeySize192) begin
      nk = 6; nr = 12;
    end else if (cfg_size == KeySize256) begin
      nk = 8; nr = 14;
    end else begin
      nk = 4; nr = 10;
    end
    for (int i = 0; i < 4; i++) begin
      w[2*i] = cfg_key[i][63:32];
      w[2*i+1] = cfg_key[i][31:0];
    end
    for (int i = nk; i < 4*(nr+1); i++) begin
      t = w[i-1];
      if (i % nk == 0) begin
        t = sub_word({t[23:0], t[31:24]}) ^ {RCON[(i/nk) % 11], 24'h0};
      end else if (nk > 6 && i % nk == 4) begin
        t = sub_word(t);
      end
      w[i] = w[i-nk] ^ t;
    end
    s = {p.hi, p.lo} ^ {w[0], w[1], w[2], w[3]};
    for (int rd = 1; rd < nr; rd++) begin
      rk = {w[4*rd], w[4*rd+1], w[4*rd+2], w[4*rd+3]};
      s = mix_columns(sub_shift(s)) ^ rk;
    end
    s = sub_shift(s) ^ {w[4*nr], w[4*nr+1], w[4*nr+2], w[4*nr+3]};
    r.hi = s[127:64];
    r.lo = s[63:0];
    return r;
  endfunction

  task automatic reg_write(input logic [AddrWidth-1:0] addr, input logic [63:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == AddrKeySize) cfg_size = val[1:0];
    else if (addr == AddrKeyWord0) cfg_key[0] = val;
    else if (addr == AddrKeyWord1) cfg_key[1] = val;
    else if (addr == AddrKeyWord2) cfg_key[2] = val;
    else if (addr == AddrKeyWord3) cfg_key[3] = val;
  endtask

  task automatic drain;
    while (pending_blocks.size() != 0 || expected_cipher.size() != 0 || start)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic load_key(input key_size_t ks, input logic [63:0] k0, k1, k2, k3);
    drain();
    reg_write(AddrKeySize, {62'd0, ks});
    reg_write(AddrKeyWord0, k0);
    reg_write(AddrKeyWord1, k1);
    reg_write(AddrKeyWord2, k2);
    reg_write(AddrKeyWord3, k3);
  endtask

  function automatic logic [63:0] rnd64();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = '1;
      default: ;
    endcase
    return v;
  endfunction

  task automatic push_block(input logic [63:0] hi, lo);
    blk_pair_t p;
    p.hi = hi;
    p.lo = lo;
    pending_blocks.push_back(p);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        expected_cipher.push_back(aes_encrypt('{plain_high, plain_low}));
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (pending_blocks.size() != 0) begin
          plain_high <= pending_blocks[0].hi;
          plain_low <= pending_blocks[0].lo;
          void'(pending_blocks.pop_front());
          start <= 1'b1;
          if (!no_gaps && $urandom_range(0, 9) == 0) gap_left <= $urandom_range(1, 12);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_cipher.size() == 0) begin
        $error("unexpected result %h %h", cipher_high, cipher_low);
        failed <= 1'b1;
      end else begin
        if (cipher_high !== expected_cipher[0].hi) begin
          $error("cipher_high expected %h actual %h", expected_cipher[0].hi, cipher_high);
          failed <= 1'b1;
        end
        if (cipher_low !== expected_cipher[0].lo) begin
          $error("cipher_low expected %h actual %h", expected_cipher[0].lo, cipher_low);
          failed <= 1'b1;
        end
        void'(expected_cipher.pop_front());
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((start && !busy) || done || psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    cfg_size = KeySize128;
    foreach (cfg_key[i]) cfg_key[i] = '0;
    gap_left = 0;
    no_gaps = 1'b0;
    failed = 1'b0;
    quiet_cycles = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // zero key after reset, field extremes
    push_block('0, '0);
    push_block('1, '1);
    push_block(64'h8000000000000000, 64'h1);
    // FIPS-197 appendix vectors
    load_key(KeySize128, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, '1, '1);
    push_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    push_block('1, '0);
    load_key(KeySize192, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
             64'h1011121314151617, '1);
    push_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    load_key(KeySize256, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
             64'h1011121314151617, 64'h18191a1b1c1d1e1f);
    push_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    push_block('0, '1);
    load_key(KeySize256, '1, '1, '1, '1);
    push_block('1, '1);
    // reserved size decodes as 128 bits
    load_key(2'd3, rnd64(), rnd64(), rnd64(), rnd64());
    push_block(rnd64(), rnd64());
    load_key(KeySize128, '0, '0, '0, '0);
    push_block('1, '1);

    for (int ph = 0; ph < 13; ph++) begin
      load_key(key_size_t'($urandom_range(0, 3)), rnd64(), rnd64(), rnd64(), rnd64());
      if (ph == 12) no_gaps = 1'b1;
      for (int i = 0; i < 100; i++) push_block(rnd64(), rnd64());
    end

    drain();
    if (!failed) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
